[design/opwr_pkg.sv]
package opwr_pkg;

    localparam int CODE_BITS  = 32;
    localparam int HALF_BITS  = 2 * CODE_BITS;
    localparam int STEP_DONE  = 2 * HALF_BITS + 2;
    localparam int STEP_W     = $clog2(STEP_DONE + 1);
    localparam int HALF_IDX_W = $clog2(HALF_BITS);

    localparam int DUR_W      = 16;
    localparam int CODE_W     = 32;
    localparam int UNIT_W     = 4;
    localparam int SENDER_W   = 26;
    localparam int CFG_IDX_W  = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MAX   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN   = 3'd7;

    localparam logic [DUR_W-1:0] RST_ACCEPT_MIN = 16'd432;
    localparam logic [DUR_W-1:0] RST_ACCEPT_MAX = 16'd5585;
    localparam logic [DUR_W-1:0] RST_HIGH_MIN   = 16'd495;
    localparam logic [DUR_W-1:0] RST_HIGH_MAX   = 16'd640;
    localparam logic [DUR_W-1:0] RST_SHORT_MAX  = 16'd650;
    localparam logic [DUR_W-1:0] RST_LONG_MIN   = 16'd2340;
    localparam logic [DUR_W-1:0] RST_LONG_MAX   = 16'd2860;
    localparam logic [DUR_W-1:0] RST_SYNC_MIN   = 16'd4815;

    // classified word handed from front to back
    typedef struct packed {
        logic release_code;
        logic in_accept;
        logic high;
        logic short_low;
        logic long_low;
        logic sync_ok;
    } pulse_class_t;

    function automatic logic in_window(logic [DUR_W-1:0] d, logic [DUR_W-1:0] lo,
                                       logic [DUR_W-1:0] hi);
        return (lo < d) && (d < hi);
    endfunction

endpackage

[design/opwr_front.sv]
module opwr_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_cmd,
    input  logic [opwr_pkg::DUR_W-1:0]       s_duration,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [opwr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [opwr_pkg::DUR_W-1:0]       cfg_data,
    input  logic                             q_full,
    output logic                             q_push,
    output opwr_pkg::pulse_class_t           q_item
);
    import opwr_pkg::*;

    logic [DUR_W-1:0] accept_min_reg, accept_max_reg, high_min_reg, high_max_reg;
    logic [DUR_W-1:0] short_max_reg, long_min_reg, long_max_reg, sync_min_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign q_push    = s_valid && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accept_min_reg <= RST_ACCEPT_MIN;
            accept_max_reg <= RST_ACCEPT_MAX;
            high_min_reg   <= RST_HIGH_MIN;
            high_max_reg   <= RST_HIGH_MAX;
            short_max_reg  <= RST_SHORT_MAX;
            long_min_reg   <= RST_LONG_MIN;
            long_max_reg   <= RST_LONG_MAX;
            sync_min_reg   <= RST_SYNC_MIN;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ACCEPT_MIN: accept_min_reg <= cfg_data;
                REG_ACCEPT_MAX: accept_max_reg <= cfg_data;
                REG_HIGH_MIN:   high_min_reg   <= cfg_data;
                REG_HIGH_MAX:   high_max_reg   <= cfg_data;
                REG_SHORT_MAX:  short_max_reg  <= cfg_data;
                REG_LONG_MIN:   long_min_reg   <= cfg_data;
                REG_LONG_MAX:   long_max_reg   <= cfg_data;
                REG_SYNC_MIN:   sync_min_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        q_item.release_code = s_cmd;
        q_item.in_accept    = in_window(s_duration, accept_min_reg, accept_max_reg);
        q_item.high         = in_window(s_duration, high_min_reg, high_max_reg);
        q_item.short_low    = in_window(s_duration, accept_min_reg, short_max_reg);
        q_item.long_low     = in_window(s_duration, long_min_reg, long_max_reg);
        q_item.sync_ok      = s_duration > sync_min_reg;
    end

endmodule

[design/opwr_queue.sv]
module opwr_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  opwr_pkg::pulse_class_t din,
    output logic                   full,
    input  logic                   pop,
    output opwr_pkg::pulse_class_t dout,
    output logic                   empty
);
    import opwr_pkg::*;

    pulse_class_t      mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[design/opwr_back.sv]
module opwr_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_empty,
    input  opwr_pkg::pulse_class_t        q_item,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          res_frame_ready,
    output logic [opwr_pkg::CODE_W-1:0]   res_code,
    output logic                          res_ignored
);
    import opwr_pkg::*;

    logic [STEP_W-1:0]     step_reg, step_next, step_mid, step_m3;
    logic [HALF_BITS-1:0]  half_reg, half_next, half_upd;
    logic [CODE_BITS-1:0]  code_reg, code_next, decoded;
    logic [HALF_IDX_W-1:0] k;
    logic                  pair_ok, ignored;

    logic                  m_valid_reg;
    logic                  frame_ready_reg, ignored_reg;
    logic [CODE_W-1:0]     code_out_reg;

    assign q_pop           = !q_empty && (!m_valid_reg || m_ready);
    assign m_valid         = m_valid_reg;
    assign res_frame_ready = frame_ready_reg;
    assign res_code        = code_out_reg;
    assign res_ignored     = ignored_reg;

    // half-bit store with the current low written, then the fixed pair check
    always_comb begin
        step_m3     = step_reg - STEP_W'(3);
        k           = step_m3[HALF_IDX_W:1];
        half_upd    = half_reg;
        half_upd[k] = !q_item.short_low;
        pair_ok     = 1'b1;
        decoded     = '0;
        for (int i = 0; i < CODE_BITS; i++) begin
            pair_ok = pair_ok & (half_upd[2*i] ^ half_upd[2*i+1]);
            decoded[CODE_BITS-1-i] = half_upd[2*i];
        end
    end

    always_comb begin
        step_next = step_reg;
        half_next = half_reg;
        code_next = code_reg;
        step_mid  = step_reg;
        ignored   = 1'b0;
        if (q_item.release_code) begin
            step_next = '0;
            half_next = '0;
            code_next = '0;
        end else if (step_reg == STEP_W'(STEP_DONE) || !q_item.in_accept) begin
            ignored = 1'b1;
        end else begin
            if (step_reg >= STEP_W'(2)) begin
                if (!step_reg[0]) begin
                    step_mid = q_item.high ? step_reg + 1'b1 : '0;
                end else if (q_item.short_low || q_item.long_low) begin
                    half_next = half_upd;
                    step_mid  = step_reg + 1'b1;
                end else begin
                    step_mid = '0;
                end
                if (step_mid == STEP_W'(STEP_DONE)) begin
                    if (pair_ok) begin
                        code_next = decoded;
                    end else begin
                        step_mid  = '0;
                        half_next = '0;
                        code_next = '0;
                    end
                end
            end else if (step_reg == STEP_W'(1)) begin
                step_mid = q_item.sync_ok ? STEP_W'(2) : '0;
            end
            // a pulse that resets the frame may itself open the next one
            step_next = (step_mid == '0 && q_item.high) ? STEP_W'(1) : step_mid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            half_reg    <= '0;
            code_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                step_reg    <= step_next;
                half_reg    <= half_next;
                code_reg    <= code_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            frame_ready_reg <= step_next == STEP_W'(STEP_DONE);
            code_out_reg    <= (step_next == STEP_W'(STEP_DONE)) ? CODE_W'(code_next) : '0;
            ignored_reg     <= ignored;
        end
    end

endmodule

[design/ook_pulse_width_remote_decoder_unit.sv]
// OOK pulse-width remote decoder. Each input word is either a pulse duration in
// timer ticks (cmd 0) or a release of the held code (cmd 1); every word returns
// exactly one result word with the held code, its unit/on-off/group/sender
// fields and a flag telling whether the pulse was dropped. A frame is a high,
// a long sync low, then 64 high/low pairs whose lows carry half-bits; pairs
// 01/10 decode to 0/1, anything else discards the frame. A decoded code stays
// held, with pulses dropped, until a release word. Throughput is one word per
// clock unless the result output stalls, set by the state update: the front
// stage classifies the duration against the window registers, a two-entry
// queue decouples it from the state update, and the result word reaches the
// output register through the queue. A stalled result output fills the queue
// and then drops s_ready. The user must write the window registers through the
// cfg port only while the block is idle; the block itself does not enforce it.
module ook_pulse_width_remote_decoder_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_cmd,
    input  logic [opwr_pkg::DUR_W-1:0]         s_duration,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_frame_ready,
    output logic [opwr_pkg::CODE_W-1:0]        m_code_word,
    output logic [opwr_pkg::UNIT_W-1:0]        m_device_unit,
    output logic                               m_on_off,
    output logic                               m_group_flag,
    output logic [opwr_pkg::SENDER_W-1:0]      m_sender_id,
    output logic                               m_pulse_ignored,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [opwr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [opwr_pkg::DUR_W-1:0]         cfg_data
);
    import opwr_pkg::*;

    pulse_class_t push_item, pop_item;
    logic         q_push, q_pop, q_full, q_empty;

    opwr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_duration (s_duration),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    opwr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (push_item),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (pop_item),
        .empty   (q_empty)
    );

    opwr_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_item          (pop_item),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .res_frame_ready (m_frame_ready),
        .res_code        (m_code_word),
        .res_ignored     (m_pulse_ignored)
    );

    assign m_device_unit = m_code_word[UNIT_W-1:0];
    assign m_on_off      = m_code_word[UNIT_W];
    assign m_group_flag  = m_code_word[UNIT_W+1];
    assign m_sender_id   = m_code_word[CODE_W-1:CODE_W-SENDER_W];

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import opwr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 16;

    typedef enum logic [1:0] {OP_WORD, OP_CFG, OP_DRAIN} op_kind_t;
    typedef enum int {P_HIGH, P_SHORT, P_LONG, P_SYNC, P_OUTSIDE, P_ANY} pulse_shape_t;

    typedef struct {
        op_kind_t             kind;
        logic                 cmd;
        logic [DUR_W-1:0]     value;
        logic [CFG_IDX_W-1:0] index;
    } op_t;

    typedef struct packed {
        logic                frame_ready;
        logic [CODE_W-1:0]   code;
        logic [UNIT_W-1:0]   unit;
        logic                on_off;
        logic                group;
        logic [SENDER_W-1:0] sender;
        logic                ignored;
    } remote_out_t;

    logic                 aclk       = 1'b0;
    logic                 aresetn    = 1'b0;
    logic                 s_valid    = 1'b0;
    logic                 s_ready;
    logic                 s_cmd      = 1'b0;
    logic [DUR_W-1:0]     s_duration = '0;
    logic                 m_valid;
    logic                 m_ready    = 1'b0;
    logic                 m_frame_ready;
    logic [CODE_W-1:0]    m_code_word;
    logic [UNIT_W-1:0]    m_device_unit;
    logic                 m_on_off;
    logic                 m_group_flag;
    logic [SENDER_W-1:0]  m_sender_id;
    logic                 m_pulse_ignored;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [DUR_W-1:0]     cfg_data   = '0;

    ook_pulse_width_remote_decoder_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_duration      (s_duration),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_ready   (m_frame_ready),
        .m_code_word     (m_code_word),
        .m_device_unit   (m_device_unit),
        .m_on_off        (m_on_off),
        .m_group_flag    (m_group_flag),
        .m_sender_id     (m_sender_id),
        .m_pulse_ignored (m_pulse_ignored),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // pending stimulus and the window settings it was built against
    op_t              pending_ops[$];
    logic [DUR_W-1:0] plan_win [8];
    int               plan_items = 0;

    // decoder mirror
    logic [DUR_W-1:0]     win [8];
    int unsigned          frame_pos;
    logic [HALF_BITS-1:0] half_store;
    logic [CODE_W-1:0]    held_code;
    remote_out_t          expected_q[$];

    int results_due = 0;
    int quiet       = 0;
    int errors      = 0;
    int pulses_seen = 0;
    int releases    = 0;
    int cfg_writes  = 0;
    int codes_done  = 0;
    int codes_lost  = 0;
    int drops       = 0;

    function automatic bit between(logic [DUR_W-1:0] d, logic [DUR_W-1:0] lo,
                                   logic [DUR_W-1:0] hi);
        return (lo < d) && (d < hi);
    endfunction

    function void clear_frame_state();
        frame_pos  = 0;
        half_store = '0;
        held_code  = '0;
    endfunction

    function void unpack_pairs();
        logic [CODE_W-1:0] code;
        code = '0;
        for (int i = 0; i < CODE_BITS; i++) begin
            if (half_store[2*i] == half_store[2*i+1]) begin
                clear_frame_state();
                codes_lost++;
                return;
            end
            // 10 -> 1, 01 -> 0; first pair lands in the top bit
            code[CODE_BITS-1-i] = half_store[2*i];
        end
        held_code = code;
        codes_done++;
    endfunction

    function remote_out_t decode_pulse(logic cmd, logic [DUR_W-1:0] d);
        remote_out_t r;
        logic        high;
        logic        dropped;
        int unsigned slot;
        dropped = 1'b0;
        if (cmd) begin
            clear_frame_state();
        end else if (frame_pos >= STEP_DONE ||
                     !between(d, win[REG_ACCEPT_MIN], win[REG_ACCEPT_MAX])) begin
            dropped = 1'b1;
            drops++;
        end else begin
            high = between(d, win[REG_HIGH_MIN], win[REG_HIGH_MAX]);
            if (frame_pos >= 2) begin
                if (frame_pos % 2 == 0) begin
                    frame_pos = high ? frame_pos + 1 : 0;
                end else begin
                    slot = (frame_pos - 3) / 2;
                    if (between(d, win[REG_ACCEPT_MIN], win[REG_SHORT_MAX])) begin
                        half_store[slot] = 1'b0;
                        frame_pos++;
                    end else if (between(d, win[REG_LONG_MIN], win[REG_LONG_MAX])) begin
                        half_store[slot] = 1'b1;
                        frame_pos++;
                    end else begin
                        frame_pos = 0;
                    end
                end
                if (frame_pos == STEP_DONE) unpack_pairs();
            end else if (frame_pos == 1) begin
                frame_pos = (d > win[REG_SYNC_MIN]) ? 2 : 0;
            end
            // a pulse that drops us back to idle may open the next frame
            if (frame_pos == 0 && high) frame_pos = 1;
        end
        r.frame_ready = (frame_pos >= STEP_DONE);
        r.code        = r.frame_ready ? held_code : '0;
        r.unit        = r.code[3:0];
        r.on_off      = r.code[4];
        r.group       = r.code[5];
        r.sender      = r.code[31:6];
        r.ignored     = dropped;
        return r;
    endfunction

    task automatic check_field(string name, logic [CODE_W-1:0] want, logic [CODE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            errors++;
        end
    endtask

    function automatic int idle_len(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // value strictly inside both windows, or anything when they do not meet
    function automatic logic [DUR_W-1:0] pick_in(int lo_a, int lo_b, int hi_a, int hi_b);
        int lo;
        int hi;
        lo = (lo_a > lo_b) ? lo_a : lo_b;
        hi = (hi_a < hi_b) ? hi_a : hi_b;
        if (hi - lo >= 2) return DUR_W'($urandom_range(lo + 1, hi - 1));
        return DUR_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [DUR_W-1:0] pulse_of(pulse_shape_t shape);
        case (shape)
            P_HIGH: begin
                return pick_in(plan_win[REG_ACCEPT_MIN], plan_win[REG_HIGH_MIN],
                               plan_win[REG_ACCEPT_MAX], plan_win[REG_HIGH_MAX]);
            end
            P_SHORT: begin
                return pick_in(plan_win[REG_ACCEPT_MIN], plan_win[REG_ACCEPT_MIN],
                               plan_win[REG_SHORT_MAX], plan_win[REG_ACCEPT_MAX]);
            end
            P_LONG: begin
                return pick_in(plan_win[REG_ACCEPT_MIN], plan_win[REG_LONG_MIN],
                               plan_win[REG_LONG_MAX], plan_win[REG_ACCEPT_MAX]);
            end
            P_SYNC: begin
                return pick_in(plan_win[REG_ACCEPT_MIN], plan_win[REG_SYNC_MIN],
                               plan_win[REG_ACCEPT_MAX], plan_win[REG_ACCEPT_MAX]);
            end
            P_OUTSIDE: begin
                if ($urandom_range(0, 1)) return DUR_W'($urandom_range(0, plan_win[REG_ACCEPT_MIN]));
                return DUR_W'($urandom_range(plan_win[REG_ACCEPT_MAX], 65535));
            end
            default: begin
                return DUR_W'($urandom_range(0, 65535));
            end
        endcase
    endfunction

    task automatic add_word(logic cmd, logic [DUR_W-1:0] dur, bit counts);
        op_t op;
        op.kind  = OP_WORD;
        op.cmd   = cmd;
        op.value = dur;
        op.index = '0;
        pending_ops.push_back(op);
        if (counts) plan_items++;
    endtask

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, int val);
        op_t op;
        op.kind  = OP_CFG;
        op.cmd   = 1'b0;
        op.value = DUR_W'(val);
        op.index = idx;
        pending_ops.push_back(op);
        plan_win[idx] = DUR_W'(val);
    endtask

    task automatic load_windows(int acc_lo, int acc_hi, int hi_lo, int hi_hi, int sh_hi,
                                int lg_lo, int lg_hi, int sy_lo);
        add_cfg(REG_ACCEPT_MIN, acc_lo);
        add_cfg(REG_ACCEPT_MAX, acc_hi);
        add_cfg(REG_HIGH_MIN, hi_lo);
        add_cfg(REG_HIGH_MAX, hi_hi);
        add_cfg(REG_SHORT_MAX, sh_hi);
        add_cfg(REG_LONG_MIN, lg_lo);
        add_cfg(REG_LONG_MAX, lg_hi);
        add_cfg(REG_SYNC_MIN, sy_lo);
    endtask

    // high, sync, then high/low per half-bit; bad_pair forces a 00 or 11 pair,
    // cut stops the frame early
    task automatic add_frame(logic [CODE_W-1:0] code, int bad_pair, int cut, bit scatter);
        int   idx;
        logic half;
        for (int p = 0; p < STEP_DONE && p < cut; p++) begin
            if (scatter && $urandom_range(0, 29) == 0) add_word(1'b0, pulse_of(P_OUTSIDE), 1'b0);
            if (p % 2 == 0) begin
                add_word(1'b0, pulse_of(P_HIGH), 1'b1);
            end else if (p == 1) begin
                add_word(1'b0, pulse_of(P_SYNC), 1'b1);
            end else begin
                idx  = (p - 3) / 2;
                half = code[CODE_BITS-1-idx/2] ^ (idx % 2 == 1);
                if (idx / 2 == bad_pair && idx % 2 == 1) half = !half;
                add_word(1'b0, pulse_of(half ? P_LONG : P_SHORT), 1'b1);
            end
        end
    endtask

    task automatic run_phase(int budget, bit frames_ok);
        int                stop;
        int                r;
        logic [CODE_W-1:0] code;
        stop = plan_items + budget;
        while (plan_items < stop) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) code = '0;
            else if ($urandom_range(0, 9) == 0) code = '1;
            else code = $urandom();
            if (frames_ok && r < 55) begin
                add_frame(code, -1, STEP_DONE, 1'b1);
                // pulses against a held code are dropped
                repeat ($urandom_range(0, 3)) add_word(1'b0, pulse_of(P_ANY), 1'b0);
                add_word(1'b1, DUR_W'($urandom_range(0, 65535)), 1'b1);
            end else if (frames_ok && r < 70) begin
                add_frame(code, $urandom_range(0, CODE_BITS - 1), STEP_DONE, 1'b1);
            end else if (frames_ok && r < 80) begin
                add_frame(code, -1, $urandom_range(2, STEP_DONE - 1), 1'b0);
                if ($urandom_range(0, 1)) add_word(1'b1, DUR_W'($urandom_range(0, 65535)), 1'b1);
            end else begin
                repeat ($urandom_range(3, 15)) begin
                    add_word($urandom_range(0, 11) == 0,
                             pulse_of(pulse_shape_t'($urandom_range(0, 5))), 1'b1);
                end
            end
        end
    endtask

    // input side: words and window writes; writes only once all results are back
    int gap_left = 0;
    bit calm_s   = 1'b0;

    always @(posedge aclk) begin
        op_t  op;
        logic send_word;
        logic send_cfg;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            cfg_valid <= 1'b0;
            gap_left = 0;
        end else if (!((s_valid && !s_ready) || (cfg_valid && !cfg_ready))) begin
            send_word = 1'b0;
            send_cfg  = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_ops.size() > 0) begin
                if (pending_ops[0].kind == OP_WORD) begin
                    op = pending_ops.pop_front();
                    s_cmd      <= op.cmd;
                    s_duration <= op.value;
                    send_word = 1'b1;
                    if ($urandom_range(0, 149) == 0) calm_s = !calm_s;
                    gap_left = idle_len(calm_s);
                end else if (results_due == 0 && !s_valid && !cfg_valid) begin
                    op = pending_ops.pop_front();
                    if (op.kind == OP_CFG) begin
                        cfg_index <= op.index;
                        cfg_data  <= op.value;
                        send_cfg = 1'b1;
                    end
                end
            end
            s_valid   <= send_word;
            cfg_valid <= send_cfg;
        end
    end

    // result side backpressure
    int stall_left = 0;
    bit calm_m     = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 199) == 0) calm_m = !calm_m;
            if (!calm_m && $urandom_range(0, 3) == 0) stall_left = idle_len(1'b0);
        end
    end

    // monitor: checks results, then mirrors newly accepted words and writes
    always @(posedge aclk) begin
        remote_out_t want;
        logic        moved;
        if (!aresetn) begin
            win[REG_ACCEPT_MIN] = RST_ACCEPT_MIN;
            win[REG_ACCEPT_MAX] = RST_ACCEPT_MAX;
            win[REG_HIGH_MIN]   = RST_HIGH_MIN;
            win[REG_HIGH_MAX]   = RST_HIGH_MAX;
            win[REG_SHORT_MAX]  = RST_SHORT_MAX;
            win[REG_LONG_MIN]   = RST_LONG_MIN;
            win[REG_LONG_MAX]   = RST_LONG_MAX;
            win[REG_SYNC_MIN]   = RST_SYNC_MIN;
            clear_frame_state();
            results_due <= 0;
            quiet       <= 0;
        end else begin
            moved = (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready);
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result word with none pending, code %h", $time, m_code_word);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("frame_ready", want.frame_ready, m_frame_ready);
                    check_field("code_word", want.code, m_code_word);
                    check_field("device_unit", want.unit, m_device_unit);
                    check_field("on_off", want.on_off, m_on_off);
                    check_field("group_flag", want.group, m_group_flag);
                    check_field("sender_id", want.sender, m_sender_id);
                    check_field("pulse_ignored", want.ignored, m_pulse_ignored);
                end
            end
            if (s_valid && s_ready) begin
                expected_q.push_back(decode_pulse(s_cmd, s_duration));
                if (s_cmd) releases++;
                else pulses_seen++;
            end
            if (cfg_valid && cfg_ready) begin
                win[cfg_index] = cfg_data;
                cfg_writes++;
            end
            results_due <= expected_q.size();
            quiet       <= moved ? 0 : quiet + 1;
        end
    end

    initial begin
        do @(posedge aclk); while (quiet < WATCHDOG_LIMIT);
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("ook_pulse_width_remote_decoder_unit: mismatch");
        $finish;
    end

    initial begin
        op_t pause;
        plan_win[REG_ACCEPT_MIN] = RST_ACCEPT_MIN;
        plan_win[REG_ACCEPT_MAX] = RST_ACCEPT_MAX;
        plan_win[REG_HIGH_MIN]   = RST_HIGH_MIN;
        plan_win[REG_HIGH_MAX]   = RST_HIGH_MAX;
        plan_win[REG_SHORT_MAX]  = RST_SHORT_MAX;
        plan_win[REG_LONG_MIN]   = RST_LONG_MIN;
        plan_win[REG_LONG_MAX]   = RST_LONG_MAX;
        plan_win[REG_SYNC_MIN]   = RST_SYNC_MIN;

        // accept window edges, all dropped or idle
        add_word(1'b0, 16'd0, 1'b0);
        add_word(1'b0, 16'hFFFF, 1'b0);
        add_word(1'b0, 16'd432, 1'b0);
        add_word(1'b0, 16'd5585, 1'b0);
        add_word(1'b0, 16'd433, 1'b1);
        add_word(1'b0, 16'd5584, 1'b1);
        add_word(1'b1, 16'hFFFF, 1'b1);        // release with nothing held
        add_word(1'b0, 16'd600, 1'b1);
        add_word(1'b0, 16'd4815, 1'b1);        // sync on its bound fails
        add_word(1'b0, 16'd496, 1'b1);
        add_word(1'b0, 16'd496, 1'b1);         // bad sync that is itself a high
        add_word(1'b0, 16'd4816, 1'b1);
        add_word(1'b0, 16'd639, 1'b1);
        add_word(1'b0, 16'd1000, 1'b1);        // low of no class
        add_word(1'b0, 16'd550, 1'b1);
        add_word(1'b0, 16'd5000, 1'b1);
        add_word(1'b0, 16'd600, 1'b1);
        add_word(1'b0, 16'd600, 1'b1);         // short low inside the high window
        add_word(1'b0, 16'd2341, 1'b1);        // non-high where a high belongs
        add_word(1'b0, 16'd550, 1'b1);
        add_word(1'b0, 16'd5000, 1'b1);
        add_word(1'b0, 16'd639, 1'b1);
        add_word(1'b0, 16'd2859, 1'b1);
        add_word(1'b1, 16'd0, 1'b1);           // release mid-frame

        run_phase(160, 1'b1);
        pause.kind  = OP_DRAIN;
        pause.cmd   = 1'b0;
        pause.value = '0;
        pause.index = '0;
        pending_ops.push_back(pause);
        run_phase(20, 1'b1);

        load_windows(0, 65535, 100, 200, 300, 1000, 2000, 60000);
        run_phase(120, 1'b1);
        // every window inverted: every pulse word is dropped
        load_windows(65535, 0, 65535, 0, 0, 65535, 0, 65535);
        run_phase(30, 1'b0);
        for (int k = 0; k < 2; k++) begin
            int t;
            t = $urandom_range(40, 1500);
            load_windows(t / 2, 10 * t + 1, t, 2 * t,
                         $urandom_range(0, 1) ? 2 * t : 2 * t + t / 2, 4 * t, 6 * t, 8 * t);
            run_phase(100, 1'b1);
        end
        load_windows(RST_ACCEPT_MIN, RST_ACCEPT_MAX, RST_HIGH_MIN, RST_HIGH_MAX,
                     RST_SHORT_MAX, RST_LONG_MIN, RST_LONG_MAX, RST_SYNC_MIN);
        run_phase(80, 1'b1);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (pending_ops.size() != 0 || s_valid || cfg_valid || results_due != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (expected_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_q.size());
            errors += expected_q.size();
        end
        $display("covered %0d pulse words, %0d releases, %0d window writes",
                 pulses_seen, releases, cfg_writes);
        $display("%0d codes decoded, %0d frames dropped on bad pairs, %0d pulses ignored",
                 codes_done, codes_lost, drops);
        if (errors == 0) begin
            $display("ook_pulse_width_remote_decoder_unit: match");
        end else begin
            $display("ook_pulse_width_remote_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
design/opwr_pkg.sv
design/opwr_front.sv
design/opwr_queue.sv
design/opwr_back.sv
design/ook_pulse_width_remote_decoder_unit.sv
sim/tb_top.sv
